// ===== hdl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, status codes and controller/datapath interface types of
// the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   // Default sizing of the bitmap.
   localparam int DEF_MAX_BLOCKS     = 1024;
   localparam int DEF_SCAN_WORD_BITS = 32;

   // Fixed field widths of the request, response and register.
   localparam int BLK_NUM_W = 10;
   localparam int CNT_W     = 11;
   localparam int STATUS_W  = 2;

   localparam logic [CNT_W-1:0] BLOCK_COUNT_RESET = 11'd1024;

   // Request operation codes.
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OUT_OF_BLOCKS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DOUBLE_FREE   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE         = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                clear_row;   // write one all-free row of the clearing pass
      logic                load_req;    // capture the request block number
      logic                rd_first;    // read bitmap row 0, start a scan
      logic                rd_blk;      // read the row holding the request block
      logic                rd_next;     // read the row after the one under check
      logic                wr_alloc;    // mark the found free block used
      logic                wr_free;     // mark the captured block free
      logic                res_load;    // capture a result
      logic                res_use_hit; // result block is the found block, else 0
      logic [STATUS_W-1:0] res_status;  // status of the captured result
      logic                rsp_load;    // move the result to the response register
   } bba_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;   // the clearing pass writes its last row
      logic limit_zero;   // no blocks are managed
      logic req_in_range; // request block number is below the block count
      logic hit;          // row under check has a free block below the count
      logic last_row;     // row under check is the last one below the count
      logic blk_used;     // captured block is marked used
      logic rsp_free;     // the response register can take a new beat
   } bba_status_type;

endpackage

// ===== hdl/bitmap_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// First-fit bitmap block allocator: one used/free bit per block, allocate
// the lowest free block below the block count, free a given block.
// ----------------------------------------------------------------------------
// The block keeps its used/free bitmap in a RAM organized in rows of
// SCAN_WORD_BITS bits, rounded up to a power of two. After reset it runs a
// clearing pass that marks every block free, row by row; no request beat
// is taken during that pass, while block count writes are not held off by
// it. An allocate beat reads one bitmap row per cycle from row 0 upward
// until it reaches the row holding the lowest free block, or the last row
// below the block count when none is free, and then captures its result. A
// free beat reads the block's row and writes it back with the block's bit
// cleared when the block is used; a free beyond the block count and an
// allocate with a block count of zero capture their result at acceptance,
// with no RAM access. One request is in flight at a time, gated by the
// single RAM read port and the row scan loop. The response sits in an
// output register, so a finished result may wait for rsp_ready while the
// block returns to idle; a following result is held internally until that
// register drains. The block count register is to be written by the user
// only while no request is in flight; the block itself does not enforce
// it. Values above MAX_BLOCKS act as MAX_BLOCKS. Status codes are 0 ok, 1
// out of blocks (granted block 0), 2 freeing a block that is already free,
// and 3 block number at or beyond the block count. The granted block field
// carries the low ten bits of the block number and is 0 for every free beat.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core #(
   parameter int MAX_BLOCKS     = bba_pkg::DEF_MAX_BLOCKS,
   parameter int SCAN_WORD_BITS = bba_pkg::DEF_SCAN_WORD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel.
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [bba_pkg::BLK_NUM_W-1:0] req_block_number,
   // Response channel.
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bba_pkg::BLK_NUM_W-1:0] rsp_granted_block,
   output logic [bba_pkg::STATUS_W-1:0]  rsp_status,
   // Block count register write port.
   input  logic                          csr_wr_en,
   input  logic [bba_pkg::CNT_W-1:0]     csr_wr_data
);

   import bba_pkg::*;

   // The controller and the datapath talk only through these two groups.
   bba_cmd_type    cmd;
   bba_status_type status;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the bitmap RAM, the block count, the scan pointer,
   // the captured result and the response register.
   bba_datapath #(
      .MAX_BLOCKS     (MAX_BLOCKS),
      .SCAN_WORD_BITS (SCAN_WORD_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_block_number  (req_block_number),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_granted_block (rsp_granted_block),
      .rsp_status        (rsp_status),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

// ===== hdl/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bba_datapath.sv =====
// ----------------------------------------------------------------------------
// bba_datapath
// Bitmap storage, row scan logic, block count register and response register
// of the bitmap block allocator.
// ----------------------------------------------------------------------------
module bba_datapath #(
   parameter int MAX_BLOCKS     = bba_pkg::DEF_MAX_BLOCKS,
   parameter int SCAN_WORD_BITS = bba_pkg::DEF_SCAN_WORD_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [bba_pkg::BLK_NUM_W-1:0]    req_block_number,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [bba_pkg::BLK_NUM_W-1:0]    rsp_granted_block,
   output logic [bba_pkg::STATUS_W-1:0]     rsp_status,
   input  logic                             csr_wr_en,
   input  logic [bba_pkg::CNT_W-1:0]        csr_wr_data,
   input  bba_pkg::bba_cmd_type             cmd,
   output bba_pkg::bba_status_type          status
);

   import bba_pkg::*;

   // Rows are the scan word rounded up to a power of two so that a block
   // number splits into row and bit by plain bit slicing.
   localparam int BIT_W     = $clog2(SCAN_WORD_BITS);
   localparam int ROW_BITS  = 2 ** BIT_W;
   localparam int BIT_IDX_W = (BIT_W > 0) ? BIT_W : 1;
   localparam int NUM_ROWS  = (MAX_BLOCKS + ROW_BITS - 1) / ROW_BITS;
   localparam int ROW_AW    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
   localparam int BLK_W     = $clog2(MAX_BLOCKS);
   localparam int LIM_W     = $clog2(MAX_BLOCKS + 1);
   localparam int CMP_W     = ((LIM_W > CNT_W) ? LIM_W : CNT_W) + 1;
   localparam int GW        = ROW_AW + BIT_IDX_W;
   localparam int DW        = ((GW > LIM_W) ? GW : LIM_W) + 1;
   localparam logic [LIM_W-1:0] LIMIT_RESET =
      (int'(BLOCK_COUNT_RESET) > MAX_BLOCKS) ? LIM_W'(MAX_BLOCKS)
                                             : LIM_W'(BLOCK_COUNT_RESET);
   localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(NUM_ROWS - 1);

   // Control registers.
   logic [LIM_W-1:0]  limit_ff, limit_in;
   logic [ROW_AW-1:0] clr_addr_ff, clr_addr_in;
   logic [ROW_AW-1:0] chk_addr_ff, chk_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [BLK_NUM_W-1:0] blk_ff, blk_in;
   logic [BLK_NUM_W-1:0] res_granted_ff, res_granted_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [BLK_NUM_W-1:0] rsp_granted_ff, rsp_granted_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   // Bitmap RAM ports.
   logic                ram_wr_en, ram_rd_en;
   logic [ROW_AW-1:0]   ram_wr_addr, ram_rd_addr;
   logic [ROW_BITS-1:0] ram_wr_data, ram_rd_data;

   // Scan and free decode.
   logic [CMP_W-1:0]     cnt_ext;
   logic [BLK_W-1:0]     req_idx, blk_idx;
   logic [ROW_AW-1:0]    req_row, blk_row;
   logic [BIT_IDX_W-1:0] blk_bit, hit_bit;
   logic [GW-1:0]        row_base, hit_block;
   logic [DW-1:0]        remaining;
   logic [ROW_BITS-1:0]  free_vec, hit_mask, blk_mask;

   bba_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (NUM_ROWS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Block count register, clamped to the bitmap size when written.
   always_comb begin
      cnt_ext  = CMP_W'(csr_wr_data);
      limit_in = limit_ff;
      if (csr_wr_en) begin
         limit_in = (cnt_ext > CMP_W'(MAX_BLOCKS)) ? LIM_W'(MAX_BLOCKS) : LIM_W'(cnt_ext);
      end
   end

   // Block number decode for the incoming and the captured request.
   always_comb begin
      req_idx  = BLK_W'(req_block_number);
      blk_idx  = BLK_W'(blk_ff);
      req_row  = ROW_AW'(req_idx >> BIT_W);
      blk_row  = ROW_AW'(blk_idx >> BIT_W);
      blk_bit  = BIT_IDX_W'(blk_idx % ROW_BITS);
      blk_mask = ROW_BITS'(1) << blk_bit;
   end

   // Free blocks of the row under check that lie below the block count,
   // and the lowest of them.
   always_comb begin
      row_base  = GW'(chk_addr_ff) << BIT_W;
      remaining = DW'(limit_ff) - DW'(row_base);
      for (int i = 0; i < ROW_BITS; i++) begin
         free_vec[i] = !ram_rd_data[i] && (DW'(i) < remaining);
      end
      hit_bit = '0;
      for (int i = ROW_BITS - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            hit_bit = BIT_IDX_W'(i);
         end
      end
      hit_mask  = ROW_BITS'(1) << hit_bit;
      hit_block = row_base | GW'(hit_bit);
   end

   // RAM access selection.
   always_comb begin
      ram_rd_en   = cmd.rd_first || cmd.rd_blk || cmd.rd_next;
      ram_rd_addr = '0;
      if (cmd.rd_blk) begin
         ram_rd_addr = req_row;
      end else if (cmd.rd_next) begin
         ram_rd_addr = chk_addr_ff + ROW_AW'(1);
      end
      ram_wr_en   = cmd.clear_row || cmd.wr_alloc || cmd.wr_free;
      ram_wr_addr = clr_addr_ff;
      ram_wr_data = '0;
      if (cmd.wr_alloc) begin
         ram_wr_addr = chk_addr_ff;
         ram_wr_data = ram_rd_data | hit_mask;
      end else if (cmd.wr_free) begin
         ram_wr_addr = blk_row;
         ram_wr_data = ram_rd_data & ~blk_mask;
      end
   end

   // Next values of the sequencing, result and response registers.
   always_comb begin
      clr_addr_in    = cmd.clear_row ? clr_addr_ff + ROW_AW'(1) : clr_addr_ff;
      chk_addr_in    = chk_addr_ff;
      if (cmd.rd_first) begin
         chk_addr_in = '0;
      end else if (cmd.rd_next) begin
         chk_addr_in = chk_addr_ff + ROW_AW'(1);
      end
      blk_in         = cmd.load_req ? req_block_number : blk_ff;
      res_granted_in = res_granted_ff;
      res_status_in  = res_status_ff;
      if (cmd.res_load) begin
         res_granted_in = cmd.res_use_hit ? BLK_NUM_W'(hit_block) : '0;
         res_status_in  = cmd.res_status;
      end
      rsp_valid_in   = rsp_valid_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_status_in  = rsp_status_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_granted_in = res_granted_ff;
         rsp_status_in  = res_status_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         clr_addr_ff  <= '0;
         chk_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         clr_addr_ff  <= clr_addr_in;
         chk_addr_ff  <= chk_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff         <= blk_in;
      res_granted_ff <= res_granted_in;
      res_status_ff  <= res_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_status_ff  <= rsp_status_in;
   end

   always_comb begin
      status.clear_done   = (clr_addr_ff == LAST_ROW);
      status.limit_zero   = (limit_ff == '0);
      status.req_in_range = (CMP_W'(req_block_number) < CMP_W'(limit_ff));
      status.hit          = |free_vec;
      status.last_row     = (remaining <= DW'(ROW_BITS));
      status.blk_used     = ram_rd_data[blk_bit];
      status.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_block = rsp_granted_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

// ===== hdl/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencing state machine of the bitmap block allocator: clearing pass,
// row scan for allocation, read-modify-write for free, result handoff.
// ----------------------------------------------------------------------------
module bba_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_func,
   output logic                    req_ready,
   input  bba_pkg::bba_status_type status,
   output bba_pkg::bba_cmd_type    cmd
);

   import bba_pkg::*;

   typedef enum logic [4:0] {
      S_CLEAR    = 5'b00001,
      S_IDLE     = 5'b00010,
      S_SCAN     = 5'b00100,
      S_FREE_CHK = 5'b01000,
      S_HAND     = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_row = 1'b1;
            if (status.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.load_req = 1'b1;
               if (req_func == FUNC_ALLOC) begin
                  if (status.limit_zero) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = ST_OUT_OF_BLOCKS;
                     state_in       = S_HAND;
                  end else begin
                     cmd.rd_first = 1'b1;
                     state_in     = S_SCAN;
                  end
               end else begin
                  if (!status.req_in_range) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = ST_RANGE;
                     state_in       = S_HAND;
                  end else begin
                     cmd.rd_blk = 1'b1;
                     state_in   = S_FREE_CHK;
                  end
               end
            end
         end
         S_SCAN: begin
            if (status.hit) begin
               cmd.wr_alloc    = 1'b1;
               cmd.res_load    = 1'b1;
               cmd.res_use_hit = 1'b1;
               cmd.res_status  = ST_OK;
               state_in        = S_HAND;
            end else if (status.last_row) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_OUT_OF_BLOCKS;
               state_in       = S_HAND;
            end else begin
               cmd.rd_next = 1'b1;
            end
         end
         S_FREE_CHK: begin
            cmd.res_load = 1'b1;
            if (status.blk_used) begin
               cmd.wr_free    = 1'b1;
               cmd.res_status = ST_OK;
            end else begin
               cmd.res_status = ST_DOUBLE_FREE;
            end
            state_in = S_HAND;
         end
         S_HAND: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-fit bitmap block allocator. A scoreboard
// class keeps its own copy of the used/free map and the block count, works
// out the expected response of every accepted request beat and checks the
// response beats in order. Plain tasks drive directed and random traffic
// under several block counts, with random idling on both channels and one
// long response hold-off that backs the block up.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic [bba_pkg::BLK_NUM_W-1:0] granted_block;
   logic [bba_pkg::STATUS_W-1:0]  status;
} alloc_result_type;

class alloc_scoreboard;
   bit                          used_map [bba_pkg::DEF_MAX_BLOCKS];
   logic [bba_pkg::CNT_W-1:0]   block_count;
   alloc_result_type            pending_results [$];
   int unsigned                 errors;
   int unsigned                 responses;
   int unsigned                 grants;
   int unsigned                 no_space;
   int unsigned                 double_frees;
   int unsigned                 range_errors;
   int unsigned                 top_grant;

   function new();
      foreach (used_map[i]) used_map[i] = 1'b0;
      block_count  = bba_pkg::BLOCK_COUNT_RESET;
      errors       = 0;
      responses    = 0;
      grants       = 0;
      no_space     = 0;
      double_frees = 0;
      range_errors = 0;
      top_grant    = 0;
   endfunction

   function void set_block_count(logic [bba_pkg::CNT_W-1:0] value);
      block_count = value;
   endfunction

   // Counts above capacity act as the capacity.
   function int unsigned managed_blocks();
      if (block_count > bba_pkg::DEF_MAX_BLOCKS) return bba_pkg::DEF_MAX_BLOCKS;
      return block_count;
   endfunction

   function bit is_full();
      int unsigned limit;
      limit = managed_blocks();
      for (int unsigned i = 0; i < limit; i++)
         if (!used_map[i]) return 1'b0;
      return 1'b1;
   endfunction

   // A used block below the count, searched from a random start; the start
   // itself when nothing is used, any block number when the count is zero.
   function logic [bba_pkg::BLK_NUM_W-1:0] pick_used();
      int unsigned limit;
      int unsigned start;
      int unsigned idx;
      limit = managed_blocks();
      if (limit == 0) return bba_pkg::BLK_NUM_W'($urandom_range(1023));
      start = $urandom_range(limit - 1);
      for (int unsigned k = 0; k < limit; k++) begin
         idx = (start + k) % limit;
         if (used_map[idx]) return bba_pkg::BLK_NUM_W'(idx);
      end
      return bba_pkg::BLK_NUM_W'(start);
   endfunction

   function void note_request(logic func, logic [bba_pkg::BLK_NUM_W-1:0] blk);
      alloc_result_type res;
      int unsigned      limit;
      limit             = managed_blocks();
      res.granted_block = '0;
      res.status        = bba_pkg::ST_OK;
      if (func == bba_pkg::FUNC_ALLOC) begin
         res.status = bba_pkg::ST_OUT_OF_BLOCKS;
         for (int unsigned i = 0; i < limit; i++) begin
            if (!used_map[i]) begin
               used_map[i]       = 1'b1;
               res.granted_block = bba_pkg::BLK_NUM_W'(i);
               res.status        = bba_pkg::ST_OK;
               break;
            end
         end
      end else if (blk >= limit) begin
         res.status = bba_pkg::ST_RANGE;
      end else if (!used_map[blk]) begin
         res.status = bba_pkg::ST_DOUBLE_FREE;
      end else begin
         used_map[blk] = 1'b0;
      end
      pending_results.push_back(res);
   endfunction

   task report_mismatch(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   task check_response(logic [bba_pkg::BLK_NUM_W-1:0] granted,
                       logic [bba_pkg::STATUS_W-1:0] status);
      alloc_result_type want;
      responses++;
      if (pending_results.size() == 0) begin
         report_mismatch($sformatf("response beat %0d with nothing pending", responses));
         return;
      end
      want = pending_results.pop_front();
      if (granted !== want.granted_block)
         report_mismatch($sformatf("beat %0d granted_block %0d, expected %0d",
                                   responses, granted, want.granted_block));
      if (status !== want.status)
         report_mismatch($sformatf("beat %0d status %0d, expected %0d",
                                   responses, status, want.status));
      case (want.status)
         bba_pkg::ST_OK: begin
            grants++;
            if (want.granted_block > top_grant) top_grant = want.granted_block;
         end
         bba_pkg::ST_OUT_OF_BLOCKS: no_space++;
         bba_pkg::ST_DOUBLE_FREE:   double_frees++;
         default:                   range_errors++;
      endcase
   endtask
endclass

module testbench;

   localparam int BLK_W = bba_pkg::BLK_NUM_W;

   // Every input of the block starts at a known value; reset is high from
   // time zero and dropped once.
   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      req_valid        = 1'b0;
   logic                      req_ready;
   logic                      req_func         = bba_pkg::FUNC_ALLOC;
   logic [BLK_W-1:0]          req_block_number = '0;
   logic                      rsp_valid;
   logic                      rsp_ready        = 1'b0;
   logic [BLK_W-1:0]          rsp_granted_block;
   logic [bba_pkg::STATUS_W-1:0] rsp_status;
   logic                      csr_wr_en        = 1'b0;
   logic [bba_pkg::CNT_W-1:0] csr_wr_data      = '0;

   // When set, both channels idle now and then; cleared for a long stretch
   // of back-to-back traffic.
   bit                        idle_on          = 1'b1;
   int unsigned               random_count;

   alloc_scoreboard sb = new();

   bitmap_block_allocator_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_block_number  (req_block_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_granted_block (rsp_granted_block),
      .rsp_status        (rsp_status),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Offers one request beat and returns at the edge that accepts it. Valid
   // is left high, so a following beat can go out with no gap; the gap
   // loop lowers it only when this side chooses to idle.
   task automatic send_request(input logic func, input logic [BLK_W-1:0] blk);
      while (idle_on && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_block_number <= blk;
      do @(posedge clock); while (!req_ready);
      sb.note_request(func, blk);
   endtask

   // The count register is only written with the block idle: the request
   // channel is closed and every pending response has drained. Each
   // request always produces a response, so an empty queue means nothing
   // is left in flight.
   task automatic write_block_count(input logic [bba_pkg::CNT_W-1:0] value);
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      sb.set_block_count(value);
      csr_wr_en   <= 1'b0;
   endtask

   // Random request content. Most frees target a block that is in use so
   // the map keeps churning; the rest hit any block below the count or any
   // block number, including ones past the count. In fill mode allocations
   // dominate until the map is full, which pushes grants all the way to the
   // top block and then into out-of-blocks answers.
   task automatic pick_random_request(input int unsigned alloc_pct, input bit fill,
                                      output logic func, output logic [BLK_W-1:0] blk);
      int unsigned roll;
      roll = $urandom_range(99);
      blk  = BLK_W'($urandom_range(1023));
      if (fill && !sb.is_full())
         func = (roll < 98) ? bba_pkg::FUNC_ALLOC : bba_pkg::FUNC_FREE;
      else
         func = (roll < alloc_pct) ? bba_pkg::FUNC_ALLOC : bba_pkg::FUNC_FREE;
      if (func == bba_pkg::FUNC_FREE) begin
         roll = $urandom_range(99);
         if (roll < 65)
            blk = sb.pick_used();
         else if (roll < 80 && sb.managed_blocks() != 0)
            blk = BLK_W'($urandom_range(sb.managed_blocks() - 1));
      end
   endtask

   task automatic run_random(input int unsigned items, input int unsigned alloc_pct,
                             input bit fill);
      logic             func;
      logic [BLK_W-1:0] blk;
      for (int unsigned n = 0; n < items; n++) begin
         pick_random_request(alloc_pct, fill, func, blk);
         send_request(func, blk);
      end
   endtask

   // Response side: checks each accepted beat against the oldest expected
   // one, then decides rsp_ready for the next cycle. After the sixtieth
   // response it holds off once while the sender keeps offering beats, so
   // the output register and the internal holding slot fill and the block
   // has to stall its request channel.
   initial begin : response_side
      int unsigned beats_seen = 0;
      int unsigned hold_left  = 0;
      bit          held       = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
            sb.check_response(rsp_granted_block, rsp_status);
            beats_seen++;
            if (beats_seen == 60 && !held) begin
               held      = 1'b1;
               hold_left = 400;
            end
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= !(idle_on && $urandom_range(99) < 14);
         end
      end
   end

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // The map comes out of reset all free, so block 0 and the other low
      // blocks go to the first allocations. Requests wait out the clearing
      // pass through the handshake.
      send_request(bba_pkg::FUNC_ALLOC, '0);
      send_request(bba_pkg::FUNC_ALLOC, '1);
      send_request(bba_pkg::FUNC_ALLOC, 10'd5);
      send_request(bba_pkg::FUNC_FREE, 10'd1);
      // Freeing the same block again is a double free.
      send_request(bba_pkg::FUNC_FREE, 10'd1);
      send_request(bba_pkg::FUNC_ALLOC, '0);
      send_request(bba_pkg::FUNC_FREE, 10'd1023);
      send_request(bba_pkg::FUNC_FREE, 10'd0);

      // With no blocks managed, allocation fails and every free is out of
      // range.
      write_block_count(11'd0);
      send_request(bba_pkg::FUNC_ALLOC, '0);
      send_request(bba_pkg::FUNC_FREE, 10'd0);
      send_request(bba_pkg::FUNC_FREE, 10'd1023);

      // Two blocks: one free slot, then out of blocks, then a free just
      // past the count.
      write_block_count(11'd2);
      send_request(bba_pkg::FUNC_ALLOC, '0);
      send_request(bba_pkg::FUNC_ALLOC, '0);
      send_request(bba_pkg::FUNC_FREE, 10'd2);
      send_request(bba_pkg::FUNC_FREE, 10'd1);

      // A count above capacity behaves like the full capacity.
      write_block_count(11'd2047);
      send_request(bba_pkg::FUNC_FREE, 10'd1023);
      send_request(bba_pkg::FUNC_ALLOC, '0);
      send_request(bba_pkg::FUNC_ALLOC, '0);

      write_block_count(11'd1);
      send_request(bba_pkg::FUNC_FREE, 10'd0);
      send_request(bba_pkg::FUNC_ALLOC, '1);
      send_request(bba_pkg::FUNC_ALLOC, '0);
      send_request(bba_pkg::FUNC_FREE, 10'd1);

      // Random phases under a spread of block counts. Counts around the
      // scan word size exercise partial last rows.
      write_block_count(11'd40);
      run_random(180, 55, 1'b0);
      write_block_count(11'd1);
      run_random(30, 50, 1'b0);
      write_block_count(11'd33);
      run_random(140, 50, 1'b0);
      random_count = $urandom_range(2, 1024);
      write_block_count(bba_pkg::CNT_W'(random_count));
      run_random(180, 50, 1'b0);

      // Fill the whole map, first with both sides running flat out.
      write_block_count(11'd2047);
      idle_on = 1'b0;
      run_random(400, 60, 1'b1);
      idle_on = 1'b1;
      run_random(680, 60, 1'b1);

      write_block_count(11'd1024);
      run_random(120, 30, 1'b0);
      write_block_count(11'd0);
      run_random(20, 50, 1'b0);

      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      // Any stray beat after the last expected one is caught here.
      repeat (40) @(posedge clock);
      if (sb.pending_results.size() != 0)
         sb.report_mismatch($sformatf("%0d responses never arrived",
                                      sb.pending_results.size()));

      $display("Checked %0d responses: %0d grants, %0d out of blocks, %0d double frees, %0d out of range.",
               sb.responses, sb.grants, sb.no_space, sb.double_frees, sb.range_errors);
      $display("Block counts 0, 1, 2, 33, 40, %0d, 1024 and 2047 were used; highest grant %0d.",
               random_count, sb.top_grant);
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // The watchdog allows several times the slowest legal run.
   initial begin : watchdog
      #(10_000_000);
      $display("simulation failed");
      $finish;
   end

endmodule
